// ===== hw/rtl/hbb_pkg.sv =====
// ----------------------------------------------------------------------------
// hbb_pkg
// Shared types and constants for the horizontal box blur block.
// ----------------------------------------------------------------------------
`default_nettype none

package hbb_pkg;

   // Geometry limits
   localparam int MAX_RADIUS  = 63;
   localparam int MAX_WIDTH   = 4096;
   localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;

   // Widths
   localparam int PIX_W   = 8;                          // one color channel
   localparam int RGB_W   = 3 * PIX_W;                  // one stored pixel
   localparam int SUM_W   = 15;                         // window sum per channel
   localparam int COL_W   = $clog2(MAX_WIDTH + 1);      // holds MAX_WIDTH itself
   localparam int ICOL_W  = $clog2(MAX_WIDTH);          // column within a row
   localparam int RAD_W   = $clog2(MAX_RADIUS + 1);
   localparam int PTR_W   = $clog2(STORE_DEPTH);
   localparam int CNT_W   = $clog2(STORE_DEPTH + 1);    // pixels in a window
   localparam int NUM_CH  = 3;

   // Divider: one quotient bit per step
   localparam int DIV_STEPS = PIX_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Channel slots
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // Register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = COL_W;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS      = 1'b1;

   localparam logic [COL_W-1:0] WIDTH_RESET  = COL_W'(640);
   localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(50);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_LOAD  = 4'b1000
   } hbb_state_type;

   // Controller -> datapath
   typedef struct packed {
      logic accept;   // take the input beat
      logic setup;    // start one result: window count, divider load, store read
      logic step;     // one divider step
      logic load;     // move quotients to output, retire oldest pixel
   } hbb_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic emit_ok;  // a result is due now
      logic more;     // row flush still has results after the current one
      logic out_free; // output register can take a new beat
   } hbb_sts_type;

endpackage

`default_nettype wire

// ===== hw/rtl/horizontal_box_blur.sv =====
// ----------------------------------------------------------------------------
// horizontal_box_blur
// Edge-normalized horizontal box blur on an RGB raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* : one RGB pixel per beat, raster order. Beat taken when req_valid
//           is high and req_stall low.
//   rsp_* : per-channel window means, truncated. rsp_last_of_run marks the
//           final result caused by one input beat.
//   csr_* : write-only; index 0 image_width, index 1 radius. Sampled at the
//           first pixel of every row, so writes during a row hit the next one.
// Results: a result is due radius pixels after its own pixel; after the beat
//   that makes it due it passes the check, 8 divide steps and the load into
//   the output register before it appears on rsp.
// Flow: a pixel is taken only while the sequencer is idle, so one that makes
//   a result holds off the next until the result is loaded. The row's last
//   pixel flushes all pending results (up to radius+1) one by one. The
//   dividers are bit-serial (one quotient bit per cycle, all three channels).
// Reset: synchronous; columns and sums clear, image_width 640, radius 50.
// Stall: the output register holds its beat while rsp_stall is high; the
//   sequencer keeps working into the dividers and waits only at the load.
// ----------------------------------------------------------------------------
`default_nettype none

module horizontal_box_blur (
   input  wire logic                              clock,
   input  wire logic                              reset,

   // pixel input
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [hbb_pkg::PIX_W-1:0]         req_in_red,
   input  wire logic [hbb_pkg::PIX_W-1:0]         req_in_green,
   input  wire logic [hbb_pkg::PIX_W-1:0]         req_in_blue,

   // blurred output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [hbb_pkg::PIX_W-1:0]         rsp_out_red,
   output logic      [hbb_pkg::PIX_W-1:0]         rsp_out_green,
   output logic      [hbb_pkg::PIX_W-1:0]         rsp_out_blue,
   output logic                                   rsp_last_of_run,

   // register writes
   input  wire logic                              csr_wr_en,
   input  wire logic [hbb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hbb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   hbb_pkg::hbb_cmd_type cmd;   // sequencer commands
   hbb_pkg::hbb_sts_type sts;   // datapath status

   // Sequencer: idle -> check -> divide -> load, looping on row flush
   hbb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Store, sums, columns, dividers and output register
   hbb_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_in_red      (req_in_red),
      .req_in_green    (req_in_green),
      .req_in_blue     (req_in_blue),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/hbb_div_lane.sv =====
// ----------------------------------------------------------------------------
// hbb_div_lane
// Restoring divider, one quotient bit per step, window sum over pixel count.
// ----------------------------------------------------------------------------
`default_nettype none

module hbb_div_lane (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic                         step,
   input  wire logic [hbb_pkg::SUM_W-1:0]    dividend,
   input  wire logic [hbb_pkg::CNT_W-1:0]    divisor,
   output logic      [hbb_pkg::PIX_W-1:0]    quotient
);

   localparam int HI_W = hbb_pkg::SUM_W - hbb_pkg::PIX_W;

   logic [hbb_pkg::CNT_W-1:0] divisor_ff;
   logic [HI_W-1:0]           rem_ff, rem_in;
   logic [hbb_pkg::PIX_W-1:0] dq_ff, dq_in;
   logic                      sat_ff, sat_in;
   logic [HI_W:0]             trial;
   logic                      ge;

   always_comb begin
      trial  = {rem_ff, dq_ff[hbb_pkg::PIX_W-1]};
      ge     = trial >= {1'b0, divisor_ff};
      rem_in = rem_ff;
      dq_in  = dq_ff;
      sat_in = sat_ff;
      if (load) begin
         rem_in = dividend[hbb_pkg::SUM_W-1:hbb_pkg::PIX_W];
         dq_in  = dividend[hbb_pkg::PIX_W-1:0];
         // quotient would not fit in a channel: clamp
         sat_in = HI_W'(dividend[hbb_pkg::SUM_W-1:hbb_pkg::PIX_W]) >= HI_W'(divisor);
      end else if (step) begin
         rem_in = ge ? HI_W'(trial - {1'b0, divisor_ff}) : trial[HI_W-1:0];
         dq_in  = {dq_ff[hbb_pkg::PIX_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         divisor_ff <= divisor;
      end
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      sat_ff <= sat_in;
   end

   assign quotient = sat_ff ? {hbb_pkg::PIX_W{1'b1}} : dq_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hbb_datapath.sv =====
// ----------------------------------------------------------------------------
// hbb_datapath
// Pixel store, window sums, column tracking, dividers and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hbb_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire hbb_pkg::hbb_cmd_type              cmd,
   output hbb_pkg::hbb_sts_type                   sts,
   input  wire logic                              csr_wr_en,
   input  wire logic [hbb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [hbb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [hbb_pkg::PIX_W-1:0]         req_in_red,
   input  wire logic [hbb_pkg::PIX_W-1:0]         req_in_green,
   input  wire logic [hbb_pkg::PIX_W-1:0]         req_in_blue,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [hbb_pkg::PIX_W-1:0]         rsp_out_red,
   output logic      [hbb_pkg::PIX_W-1:0]         rsp_out_green,
   output logic      [hbb_pkg::PIX_W-1:0]         rsp_out_blue,
   output logic                                   rsp_last_of_run
);

   localparam int COL_W  = hbb_pkg::COL_W;
   localparam int ICOL_W = hbb_pkg::ICOL_W;
   localparam int RAD_W  = hbb_pkg::RAD_W;
   localparam int PTR_W  = hbb_pkg::PTR_W;
   localparam int SUM_W  = hbb_pkg::SUM_W;
   localparam int PIX_W  = hbb_pkg::PIX_W;
   localparam int NUM_CH = hbb_pkg::NUM_CH;

   // config and per-row settings
   logic [COL_W-1:0]  width_cfg_ff;
   logic [RAD_W-1:0]  radius_cfg_ff;
   logic [COL_W-1:0]  row_width_ff;
   logic [RAD_W-1:0]  row_radius_ff;

   // columns and store pointers
   logic [ICOL_W-1:0] in_col_ff, in_col_in;
   logic [ICOL_W-1:0] cur_col_ff;
   logic [COL_W-1:0]  out_col_ff;
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic              flush_ff;

   logic [SUM_W-1:0]  sum_ff [NUM_CH];
   logic [PIX_W-1:0]  in_px  [NUM_CH];
   logic [PIX_W-1:0]  old_px [NUM_CH];
   logic [PIX_W-1:0]  quo    [NUM_CH];

   logic [hbb_pkg::RGB_W-1:0] store_mem [hbb_pkg::STORE_DEPTH];
   logic [hbb_pkg::RGB_W-1:0] rd_data_ff;

   logic              rsp_valid_ff;

   // accept-time decode
   logic              row_start;
   logic [COL_W-1:0]  width_eff;
   logic [COL_W-1:0]  row_width_use;
   logic [PTR_W-1:0]  wr_ptr_use;
   logic              is_last;

   // window count for the result being set up
   logic [COL_W-1:0]  cur_col_x;
   logic [COL_W-1:0]  radius_x;
   logic [COL_W-1:0]  win_lo;
   logic [COL_W-1:0]  win_hi_raw;
   logic [COL_W-1:0]  win_hi;
   logic [hbb_pkg::CNT_W-1:0] win_cnt;
   logic              retire;

   assign in_px[hbb_pkg::CH_RED]   = req_in_red;
   assign in_px[hbb_pkg::CH_GREEN] = req_in_green;
   assign in_px[hbb_pkg::CH_BLUE]  = req_in_blue;

   assign old_px[hbb_pkg::CH_RED]   = rd_data_ff[3*PIX_W-1:2*PIX_W];
   assign old_px[hbb_pkg::CH_GREEN] = rd_data_ff[2*PIX_W-1:PIX_W];
   assign old_px[hbb_pkg::CH_BLUE]  = rd_data_ff[PIX_W-1:0];

   always_comb begin
      row_start = in_col_ff == '0;
      if (width_cfg_ff == '0) begin
         width_eff = COL_W'(1);
      end else if (width_cfg_ff > COL_W'(hbb_pkg::MAX_WIDTH)) begin
         width_eff = COL_W'(hbb_pkg::MAX_WIDTH);
      end else begin
         width_eff = width_cfg_ff;
      end
      row_width_use = row_start ? width_eff : row_width_ff;
      wr_ptr_use    = row_start ? '0 : wr_ptr_ff;
      is_last       = ({1'b0, in_col_ff} + COL_W'(1)) >= row_width_use;
      in_col_in     = is_last ? '0 : in_col_ff + ICOL_W'(1);
   end

   always_comb begin
      cur_col_x  = {1'b0, cur_col_ff};
      radius_x   = COL_W'(row_radius_ff);
      win_lo     = (out_col_ff > radius_x) ? out_col_ff - radius_x : '0;
      win_hi_raw = out_col_ff + radius_x;
      win_hi     = (win_hi_raw > cur_col_x) ? cur_col_x : win_hi_raw;
      win_cnt    = hbb_pkg::CNT_W'(win_hi - win_lo + COL_W'(1));
      retire     = out_col_ff >= radius_x;
   end

   // status
   assign sts.emit_ok  = (out_col_ff <= cur_col_x) &&
                         (flush_ff || (cur_col_x >= radius_x));
   assign sts.more     = flush_ff && (out_col_ff != cur_col_x);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= hbb_pkg::WIDTH_RESET;
         radius_cfg_ff <= hbb_pkg::RADIUS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            hbb_pkg::CSR_IMAGE_WIDTH: width_cfg_ff  <= csr_wdata;
            hbb_pkg::CSR_RADIUS:      radius_cfg_ff <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // pixel store: written on accept, read at retire pointer on setup
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         store_mem[wr_ptr_use] <= {req_in_red, req_in_green, req_in_blue};
      end
      if (cmd.setup) begin
         rd_data_ff <= store_mem[rd_ptr_ff];
      end
   end

   // row state and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff  <= hbb_pkg::WIDTH_RESET;
         row_radius_ff <= hbb_pkg::RADIUS_RESET;
         in_col_ff     <= '0;
         cur_col_ff    <= '0;
         out_col_ff    <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         flush_ff      <= 1'b0;
         for (int i = 0; i < NUM_CH; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (cmd.accept) begin
         if (row_start) begin
            row_width_ff  <= width_eff;
            row_radius_ff <= radius_cfg_ff;
            out_col_ff    <= '0;
            rd_ptr_ff     <= '0;
         end
         for (int i = 0; i < NUM_CH; i++) begin
            sum_ff[i] <= (row_start ? '0 : sum_ff[i]) + SUM_W'(in_px[i]);
         end
         wr_ptr_ff  <= (wr_ptr_use == PTR_W'(hbb_pkg::STORE_DEPTH - 1)) ?
                       '0 : wr_ptr_use + PTR_W'(1);
         cur_col_ff <= in_col_ff;
         flush_ff   <= is_last;
         in_col_ff  <= in_col_in;
      end else if (cmd.load) begin
         if (retire) begin
            for (int i = 0; i < NUM_CH; i++) begin
               sum_ff[i] <= sum_ff[i] - SUM_W'(old_px[i]);
            end
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(hbb_pkg::STORE_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + PTR_W'(1);
         end
         out_col_ff <= out_col_ff + COL_W'(1);
      end
   end

   // one divider per channel
   for (genvar g = 0; g < NUM_CH; g++) begin : g_div
      hbb_div_lane u_div (
         .clock    (clock),
         .load     (cmd.setup),
         .step     (cmd.step),
         .dividend (sum_ff[g]),
         .divisor  (win_cnt),
         .quotient (quo[g])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_out_red     <= quo[hbb_pkg::CH_RED];
         rsp_out_green   <= quo[hbb_pkg::CH_GREEN];
         rsp_out_blue    <= quo[hbb_pkg::CH_BLUE];
         rsp_last_of_run <= !sts.more;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // a new beat shows up only from a load
   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load))
      else $error("rsp_valid rose without a load");

endmodule

`default_nettype wire

// ===== hw/rtl/hbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbb_ctrl
// Sequencer: accept a pixel, then run one divide per due result.
// ----------------------------------------------------------------------------
`default_nettype none

module hbb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output hbb_pkg::hbb_cmd_type        cmd,
   input  wire hbb_pkg::hbb_sts_type   sts
);

   localparam int STEP_W = hbb_pkg::STEP_W;

   hbb_pkg::hbb_state_type state_ff, state_in;
   logic [STEP_W-1:0]      step_cnt_ff, step_cnt_in;
   logic                   step_done;

   assign step_done = step_cnt_ff == STEP_W'(hbb_pkg::DIV_STEPS - 1);

   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      cmd         = '0;
      unique case (state_ff)
         hbb_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = hbb_pkg::ST_CHECK;
            end
         end
         hbb_pkg::ST_CHECK: begin
            if (sts.emit_ok) begin
               cmd.setup   = 1'b1;
               step_cnt_in = '0;
               state_in    = hbb_pkg::ST_DIV;
            end else begin
               state_in = hbb_pkg::ST_IDLE;
            end
         end
         hbb_pkg::ST_DIV: begin
            cmd.step    = 1'b1;
            step_cnt_in = step_cnt_ff + STEP_W'(1);
            if (step_done) begin
               state_in = hbb_pkg::ST_LOAD;
            end
         end
         hbb_pkg::ST_LOAD: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = sts.more ? hbb_pkg::ST_CHECK : hbb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hbb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= hbb_pkg::ST_IDLE;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

   assign req_stall = state_ff != hbb_pkg::ST_IDLE;

   a_accept_then_check: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == hbb_pkg::ST_CHECK)
      else $error("accepted pixel not followed by check");

   a_div_length: assert property (@(posedge clock) disable iff (reset)
      cmd.setup |-> ##(hbb_pkg::DIV_STEPS + 1) state_ff == hbb_pkg::ST_LOAD)
      else $error("divide did not finish in the expected steps");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> sts.out_free)
      else $error("load while output register still held");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the horizontal box blur. Each pixel beat that is taken is run
// through a software copy of the blur: the window store, the running sums and
// the row columns. The predicted means go into a queue, and every result beat
// is compared field by field with the oldest entry. The tests cover the
// directed edge cases, back-pressure, a gap-free stretch, and random row
// geometries.
// ----------------------------------------------------------------------------

module tb_top;
   import hbb_pkg::*;

   localparam int SETTLE_CYCLES  = 32;
   localparam int IDLE_PCT       = 38;      // idle cycles per hundred, each side
   localparam int DEFAULT_WIDTH  = 640;
   localparam int DEFAULT_RADIUS = 50;
   localparam int RANDOM_PIXELS  = 180;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             last;
   } blur_beat_type;

   // ---------------------------------------------------------------------
   // DUT ports; every input has a known value from time zero
   // ---------------------------------------------------------------------
   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic [PIX_W-1:0]      req_in_red   = '0;
   logic [PIX_W-1:0]      req_in_green = '0;
   logic [PIX_W-1:0]      req_in_blue  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic [PIX_W-1:0]      rsp_out_red;
   logic [PIX_W-1:0]      rsp_out_green;
   logic [PIX_W-1:0]      rsp_out_blue;
   logic                  rsp_last_of_run;
   logic                  csr_wr_en    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index    = '0;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   horizontal_box_blur uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_red      (req_in_red),
      .req_in_green    (req_in_green),
      .req_in_blue     (req_in_blue),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shared testbench state
   // ---------------------------------------------------------------------
   blur_beat_type blurred_q[$];     // predicted means, oldest first
   blur_beat_type oldest_mean;
   int         fail_count   = 0;
   int         pixels_sent  = 0;
   bit         req_gaps_on  = 1'b1;
   bit         rsp_gaps_on  = 1'b1;
   int         hold_request = 0;    // set by a test, picked up by the stall process
   int         hold_left    = 0;

   // ---------------------------------------------------------------------
   // Blur predictor: own copy of registers, row latches, store and sums
   // ---------------------------------------------------------------------
   logic [CSR_DATA_W-1:0] reg_width      = CSR_DATA_W'(DEFAULT_WIDTH);
   logic [RAD_W-1:0]      reg_radius     = RAD_W'(DEFAULT_RADIUS);
   logic [COL_W-1:0]      row_width_lat  = COL_W'(DEFAULT_WIDTH);
   logic [RAD_W-1:0]      row_radius_lat = RAD_W'(DEFAULT_RADIUS);
   logic [RGB_W-1:0]      win_px [STORE_DEPTH];
   logic [SUM_W-1:0]      sum_r = '0, sum_g = '0, sum_b = '0;
   logic [ICOL_W-1:0]     next_in_col  = '0;
   logic [COL_W-1:0]      next_out_col = '0;   // can reach MAX_WIDTH mid-flush

   // Register value 0 means a one-pixel row; anything past MAX_WIDTH clips.
   function automatic int eff_width(input logic [CSR_DATA_W-1:0] w);
      if (w == 0) return 1;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return int'(w);
   endfunction

   function automatic logic [PIX_W-1:0] sat8(input int v);
      return (v > 255) ? PIX_W'(255) : PIX_W'(v);
   endfunction

   // One window mean for column next_out_col, given the newest column cur.
   // The pixel leaving the window is retired once the window is full on the left.
   task automatic push_mean(input int cur, input logic last);
      int               o, lo, hi, cnt;
      logic [RGB_W-1:0] px;
      blur_beat_type    beat;
      o  = int'(next_out_col);
      lo = (o > row_radius_lat) ? o - row_radius_lat : 0;
      hi = o + row_radius_lat;
      if (hi > cur) hi = cur;
      cnt = hi - lo + 1;
      beat.red   = sat8(int'(sum_r) / cnt);
      beat.green = sat8(int'(sum_g) / cnt);
      beat.blue  = sat8(int'(sum_b) / cnt);
      beat.last  = last;
      blurred_q.push_back(beat);
      if (o >= row_radius_lat) begin
         px    = win_px[(o - row_radius_lat) % STORE_DEPTH];
         sum_r = sum_r - px[3*PIX_W-1:2*PIX_W];
         sum_g = sum_g - px[2*PIX_W-1:PIX_W];
         sum_b = sum_b - px[PIX_W-1:0];
      end
      next_out_col = COL_W'(o + 1);
   endtask

   task automatic predict_blur(input logic [PIX_W-1:0] r, g, b);
      int c, due, i;
      // row settings are latched on the first pixel of each row
      if (next_in_col == 0) begin
         row_width_lat  = COL_W'(eff_width(reg_width));
         row_radius_lat = (reg_radius > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : reg_radius;
         next_out_col   = '0;
         sum_r = '0;
         sum_g = '0;
         sum_b = '0;
      end
      c = int'(next_in_col);
      win_px[c % STORE_DEPTH] = {r, g, b};
      sum_r = sum_r + r;
      sum_g = sum_g + g;
      sum_b = sum_b + b;
      if (c + 1 >= row_width_lat) begin
         // row end: flush every pending column, last flag on the final one
         due = c + 1 - int'(next_out_col);
         if (due > MAX_RADIUS + 1) due = MAX_RADIUS + 1;
         for (i = 0; i < due; i++) push_mean(c, i == due - 1);
         sum_r = '0;
         sum_g = '0;
         sum_b = '0;
         next_in_col  = '0;
         next_out_col = '0;
      end else begin
         if (c >= row_radius_lat && next_out_col <= c) push_mean(c, 1'b1);
         next_in_col = ICOL_W'(c + 1);
      end
   endtask

   // ---------------------------------------------------------------------
   // Driver tasks
   // ---------------------------------------------------------------------
   function automatic logic [PIX_W-1:0] rand_chan();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom_range(255));
      endcase
   endfunction

   // Offer one pixel beat; valid stays up (payload frozen) until taken.
   task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
      while (req_gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_red   <= r;
      req_in_green <= g;
      req_in_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_blur(r, g, b);
      pixels_sent++;
   endtask

   task automatic send_random(input int count);
      repeat (count) send_pixel(rand_chan(), rand_chan(), rand_chan());
   endtask

   // Sender pauses until every predicted beat has come out, then lets the
   // sequencer settle so a register write lands on an idle block.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (idx == CSR_IMAGE_WIDTH) reg_width = data;
      else reg_radius = data[RAD_W-1:0];
   endtask

   // Radius write carries random junk above its 6 bits; the block drops it.
   task automatic set_geometry(input int w, input int rad);
      logic [CSR_DATA_W-1:0] word;
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(w));
      word = CSR_DATA_W'($urandom);
      word[RAD_W-1:0] = RAD_W'(rad);
      write_csr(CSR_RADIUS, word);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stalls, plus a long hold-off counted here on request
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= rsp_gaps_on && ($urandom_range(99) < IDLE_PCT);
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Every result beat taken is matched against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (blurred_q.size() == 0) begin
            $error("result beat with nothing predicted: red %0d green %0d blue %0d",
                   rsp_out_red, rsp_out_green, rsp_out_blue);
            fail_count++;
         end else begin
            oldest_mean = blurred_q.pop_front();
            check_field("out_red",     oldest_mean.red,   rsp_out_red);
            check_field("out_green",   oldest_mean.green, rsp_out_green);
            check_field("out_blue",    oldest_mean.blue,  rsp_out_blue);
            check_field("last_of_run", oldest_mean.last,  rsp_last_of_run);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Only width written: radius keeps its reset value 50, which is not below
   // the 12-pixel row, so nothing comes out until the last pixel flushes all.
   task automatic test_radius_default();
      int i;
      write_csr(CSR_IMAGE_WIDTH, CSR_DATA_W'(12));
      for (i = 0; i < 12; i++)
         send_pixel((i % 2) ? '1 : '0, (i < 6) ? '1 : '0, rand_chan());
      wait_idle();
   endtask

   // Width 0 acts as one-pixel rows; radius word has all upper bits set.
   task automatic test_single_pixel_rows();
      write_csr(CSR_IMAGE_WIDTH, '0);
      write_csr(CSR_RADIUS, {{(CSR_DATA_W-RAD_W){1'b1}}, {RAD_W{1'b0}}});
      send_pixel('1, '1, '1);
      send_pixel('0, '0, '0);
      wait_idle();
   endtask

   task automatic test_max_radius();
      set_geometry(4, MAX_RADIUS);
      send_random(4);
      wait_idle();
   endtask

   // A write in the middle of a row must only apply from the next row.
   task automatic test_midrow_write();
      set_geometry(5, 1);
      send_random(3);
      wait_idle();
      set_geometry(3, 2);
      send_random(2);
      send_random(3);
      wait_idle();
   endtask

   // Receiver holds off while the sender keeps going, so the block backs up
   // and stalls its input; then the sender waits for the whole row to drain.
   task automatic test_backpressure();
      set_geometry(40, 2);
      req_gaps_on  = 1'b0;
      hold_request = 400;
      send_random(40);
      req_gaps_on = 1'b1;
      wait_idle();
   endtask

   task automatic test_no_idle();
      set_geometry(30, 5);
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      send_random(60);
      wait_idle();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // Random geometries, mostly short rows; some rows split by a register write.
   task automatic test_random_rows();
      int target, sel, w, rad, rows, k, w_eff;
      target = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < target) begin
         sel = $urandom_range(15);
         if (sel == 0) w = 0;
         else if (sel < 3) w = $urandom_range(25, 160);
         else w = $urandom_range(1, 24);
         w_eff = eff_width(CSR_DATA_W'(w));
         if ($urandom_range(1)) rad = $urandom_range(0, MAX_RADIUS);
         else rad = $urandom_range(0, (w_eff > MAX_RADIUS) ? MAX_RADIUS : w_eff);
         set_geometry(w, rad);
         rows = $urandom_range(1, 3);
         repeat (rows) send_random(w_eff);
         if ($urandom_range(4) == 0 && w_eff > 1) begin
            k = $urandom_range(1, w_eff - 1);
            send_random(k);
            wait_idle();
            w = $urandom_range(1, 24);
            set_geometry(w, $urandom_range(0, MAX_RADIUS));
            send_random(w_eff - k);
            send_random(eff_width(CSR_DATA_W'(w)));
         end
         wait_idle();
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_radius_default();
      test_single_pixel_rows();
      test_max_radius();
      test_midrow_write();
      test_backpressure();
      test_no_idle();
      test_random_rows();
      wait_idle();
      if (fail_count == 0 && blurred_q.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #2_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/hbb_pkg.sv
hw/rtl/hbb_div_lane.sv
hw/rtl/hbb_datapath.sv
hw/rtl/hbb_ctrl.sv
hw/rtl/horizontal_box_blur.sv
tb/sv/tb_top.sv
